### hdl/slid_pkg.sv
// Package for the sorted list store: operation and status codes, the
// control struct that the top level hands to every cell. No dependencies.
package slid_pkg;

    localparam int unsigned VALUE_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_REMOVED   = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                      op;
        logic                      eval;
        logic                      apply_insert;
        logic                      apply_delete;
        logic signed [VALUE_W-1:0] key;
    } cell_ctrl_t;

endpackage

### hdl/slid_cell.sv
// One cell of the sorted row: holds one entry, compares it against the
// request key and shifts with its neighbors. Depends on slid_pkg.
module slid_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slid_pkg::cell_ctrl_t              ctrl,
    input  logic [CW-1:0]                     count,
    input  logic signed [slid_pkg::VALUE_W-1:0] prev_entry,
    input  logic                              prev_mark,
    input  logic signed [slid_pkg::VALUE_W-1:0] next_entry,
    output logic signed [slid_pkg::VALUE_W-1:0] entry,
    output logic                              mark,
    output logic                              hit
);

    logic signed [slid_pkg::VALUE_W-1:0] entry_reg;
    logic signed [slid_pkg::VALUE_W-1:0] entry_next;
    logic                                mark_reg;
    logic                                mark_next;
    logic                                eq_reg;
    logic                                eq_next;
    logic                                occupied;

    assign occupied = (count > CW'(INDEX));

    // For an insert the mark flags every slot at or after the insertion
    // point; for a delete it flags occupied slots holding a value not below
    // the key, so the first marked slot is the only candidate for removal.
    always_comb
    begin
        mark_next = mark_reg;
        eq_next   = eq_reg;
        if (ctrl.eval)
        begin
            if (ctrl.op == slid_pkg::OP_INSERT)
            begin
                mark_next = !occupied || (entry_reg > ctrl.key);
            end
            else
            begin
                mark_next = occupied && (entry_reg >= ctrl.key);
            end
            eq_next = (entry_reg == ctrl.key);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.apply_insert)
        begin
            if (prev_mark)
            begin
                entry_next = prev_entry;
            end
            else if (mark_reg)
            begin
                entry_next = ctrl.key;
            end
        end
        else if (ctrl.apply_delete)
        begin
            if (mark_reg)
            begin
                entry_next = next_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
            eq_reg   <= eq_next;
        end
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;
    assign hit   = mark_reg && !prev_mark && eq_reg;

endmodule

### hdl/sorted_list_insert_delete_top.sv
// Sorted multiset store built as a row of compare-and-shift cells.
// An accepted request runs the compare pass through the cells (ST_EVAL),
// then the shift pass that loads the result (ST_APPLY), which waits while
// a held result is stalled. A new request is taken only back in ST_IDLE.
// Reset clears the entry count, the cell flags and the handshake state;
// the entry registers are not reset and are read only below the count.
module sorted_list_insert_delete_top #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [slid_pkg::VALUE_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [slid_pkg::VALUE_W-1:0] removed_value,
    output logic [4:0]                          entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY
    } state_t;

    state_t                              state_reg;
    logic                                op_reg;
    logic signed [slid_pkg::VALUE_W-1:0] key_reg;
    logic [CW-1:0]                       count_reg;
    logic                                out_valid_reg;
    logic [1:0]                          status_reg;
    logic signed [slid_pkg::VALUE_W-1:0] removed_reg;
    logic [CW-1:0]                       count_out_reg;

    logic                                in_accept;
    logic                                go;
    logic                                full;
    logic                                found;
    logic [CW-1:0]                       count_next;
    logic [1:0]                          status_next;
    logic signed [slid_pkg::VALUE_W-1:0] removed_next;
    logic [CW+4:0]                       count_wide;
    slid_pkg::cell_ctrl_t                ctrl;

    logic signed [slid_pkg::VALUE_W-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]                 marks;
    logic [CAPACITY-1:0]                 hits;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign go        = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);
    assign full      = (count_reg == CW'(CAPACITY));
    assign found     = |hits;

    always_comb
    begin
        ctrl.op           = op_reg;
        ctrl.key          = key_reg;
        ctrl.eval         = (state_reg == ST_EVAL);
        ctrl.apply_insert = go && (op_reg == slid_pkg::OP_INSERT) && !full;
        ctrl.apply_delete = go && (op_reg == slid_pkg::OP_DELETE) && found;
    end

    always_comb
    begin
        count_next   = count_reg;
        removed_next = slid_pkg::INT_MIN;
        if (op_reg == slid_pkg::OP_INSERT)
        begin
            if (full)
            begin
                status_next = slid_pkg::STATUS_FULL;
            end
            else
            begin
                status_next = slid_pkg::STATUS_INSERTED;
                count_next  = count_reg + CW'(1);
            end
        end
        else if (found)
        begin
            status_next  = slid_pkg::STATUS_REMOVED;
            removed_next = key_reg;
            count_next   = count_reg - CW'(1);
        end
        else
        begin
            status_next = slid_pkg::STATUS_NOT_FOUND;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [slid_pkg::VALUE_W-1:0] prev_entry;
            logic                                prev_mark;
            logic signed [slid_pkg::VALUE_W-1:0] next_entry;

            if (gi == 0)
            begin : g_first
                assign prev_entry = key_reg;
                assign prev_mark  = 1'b0;
            end
            else
            begin : g_inner
                assign prev_entry = entries[gi-1];
                assign prev_mark  = marks[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_entry = entries[gi];
            end
            else
            begin : g_body
                assign next_entry = entries[gi+1];
            end

            slid_cell #(
                .CW    (CW),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .count      (count_reg),
                .prev_entry (prev_entry),
                .prev_mark  (prev_mark),
                .next_entry (next_entry),
                .entry      (entries[gi]),
                .mark       (marks[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= operation;
            key_reg <= value;
        end
        if (go)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            count_out_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (go)
                    begin
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign count_wide    = {5'b0, count_out_reg};
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = count_wide[4:0];

endmodule

### hdl/slid_checker.sv
// Port-level checks for the sorted list store, bound to the top level.
// Depends on slid_pkg and sorted_list_insert_delete_top.
module slid_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [1:0]                          status,
    input logic signed [slid_pkg::VALUE_W-1:0] removed_value,
    input logic [4:0]                          entry_count
);

    localparam logic [4:0] FULL_COUNT = 5'(CAPACITY);

    // A request is taken only when no other one is in flight.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in progress");

    // A full result reports the store at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == slid_pkg::STATUS_FULL |-> entry_count == FULL_COUNT)
        else $error("full status with count below capacity");

    // Only a removal carries a value other than the most negative one.
    a_removed_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != slid_pkg::STATUS_REMOVED
        |-> removed_value == slid_pkg::INT_MIN)
        else $error("value reported without a removal");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
        && $stable(removed_value) && $stable(entry_count))
        else $error("stalled result changed");

endmodule

bind sorted_list_insert_delete_top slid_checker #(
    .CAPACITY (CAPACITY)
) u_slid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
);

### tb/sorted_list_insert_delete_top_tb.sv
// Testbench for sorted_list_insert_delete_top: directed and random insert and delete
// requests with random idling on both sides, checked against an in-bench sorted store.
// Depends on slid_pkg and the top level of the block.
module sorted_list_insert_delete_top_tb;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_ITEMS = 60;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 70;
    localparam int MAX_REPORTS = 10;
    localparam logic signed [slid_pkg::VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]                          status;
        logic signed [slid_pkg::VALUE_W-1:0] removed;
        logic [4:0]                          count;
    } store_result_t;

    // Mirror of the block's store: ascending entries and the number held.
    class sorted_store_model;
        logic signed [slid_pkg::VALUE_W-1:0] entries [CAPACITY];
        int                                  held;
        int                                  fail_count;
        store_result_t                       awaited_results [$];

        function new();
            held = 0;
            fail_count = 0;
        endfunction

        function void note_request(logic op, logic signed [slid_pkg::VALUE_W-1:0] val);
            store_result_t r;
            int            pos;
            int            i;
            r.removed = slid_pkg::INT_MIN;
            pos = 0;
            if (op == slid_pkg::OP_INSERT)
            begin
                if (held >= CAPACITY)
                begin
                    r.status = slid_pkg::STATUS_FULL;
                end
                else
                begin
                    // Equal entries stay ahead of the new one.
                    while (pos < held && entries[pos] <= val)
                        pos++;
                    for (i = held; i > pos; i--)
                        entries[i] = entries[i-1];
                    entries[pos] = val;
                    held++;
                    r.status = slid_pkg::STATUS_INSERTED;
                end
            end
            else
            begin
                while (pos < held && entries[pos] != val)
                    pos++;
                if (pos >= held)
                begin
                    r.status = slid_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    for (i = pos; i + 1 < held; i++)
                        entries[i] = entries[i+1];
                    held--;
                    r.status = slid_pkg::STATUS_REMOVED;
                    r.removed = val;
                end
            end
            r.count = 5'(held);
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [slid_pkg::VALUE_W-1:0] rv,
                                   logic [4:0] cnt);
            store_result_t e;
            if (awaited_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Unexpected result: status %0d removed %0d count %0d",
                             st, rv, cnt);
                return;
            end
            e = awaited_results.pop_front();
            if (st !== e.status || rv !== e.removed || cnt !== e.count)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             e.status, e.removed, e.count, st, rv, cnt);
            end
        endfunction

        function logic signed [slid_pkg::VALUE_W-1:0] pick_stored();
            return entries[$urandom_range(held - 1, 0)];
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                operation = slid_pkg::OP_INSERT;
    logic signed [slid_pkg::VALUE_W-1:0] value = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [1:0]                          status;
    logic signed [slid_pkg::VALUE_W-1:0] removed_value;
    logic [4:0]                          entry_count;

    sorted_store_model store_chk = new();
    int                accepted = 0;
    bit                tail_phase = 1'b0;

    sorted_list_insert_delete_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .removed_value(removed_value),
        .entry_count(entry_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            store_chk.check_result(status, removed_value, entry_count);
    end

    // Result side: short random stalls, one long hold-off in mid run, none at the tail.
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(5, 0) == 0)
            begin
                stall_left = $urandom_range(4, 1) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic op,
                                input logic signed [slid_pkg::VALUE_W-1:0] val);
        int gap;
        gap = 0;
        if (!tail_phase && $urandom_range(5, 0) == 0)
            gap = $urandom_range(4, 1);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        value <= val;
        do
            @(posedge clk);
        while (in_stall);
        store_chk.note_request(op, val);
        accepted++;
    endtask

    function automatic logic signed [slid_pkg::VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 4)
            return $signed(32'($urandom_range(8, 0))) - 4;
        if (pick == 4)
        begin
            case ($urandom_range(3, 0))
                0: return slid_pkg::INT_MIN;
                1: return INT_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int n;
        int k;
        int insert_pct;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, extremes, duplicates, misses, fill to full.
        send_request(slid_pkg::OP_DELETE, 7);
        send_request(slid_pkg::OP_INSERT, slid_pkg::INT_MIN);
        send_request(slid_pkg::OP_INSERT, INT_MAX);
        send_request(slid_pkg::OP_INSERT, 0);
        send_request(slid_pkg::OP_INSERT, -1);
        send_request(slid_pkg::OP_INSERT, 0);
        send_request(slid_pkg::OP_DELETE, 0);
        send_request(slid_pkg::OP_DELETE, 12345);
        send_request(slid_pkg::OP_DELETE, slid_pkg::INT_MIN);
        for (k = 0; k < 13; k++)
            send_request(slid_pkg::OP_INSERT, random_value());
        send_request(slid_pkg::OP_INSERT, 3);
        send_request(slid_pkg::OP_DELETE, INT_MAX);

        // Random: blocks that mostly fill, mostly drain, or mix, so the store
        // swings between empty and full many times.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            case ((n / 40) % 3)
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            if ($urandom_range(99, 0) < insert_pct)
                send_request(slid_pkg::OP_INSERT, random_value());
            else if (store_chk.held > 0 && $urandom_range(9, 0) < 7)
                send_request(slid_pkg::OP_DELETE, store_chk.pick_stored());
            else
                send_request(slid_pkg::OP_DELETE, random_value());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (store_chk.awaited_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (store_chk.fail_count == 0 && store_chk.awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
